// ----- hdl/fpf_pkg.sv -----
// shared types and constants for the fletcher-16 packet framer
`default_nettype none
package fpf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    STEP_FIRST,
    STEP_HDR1,
    STEP_HDR2,
    STEP_CHK0,
    STEP_CHK1
  } step_e;

  // classified work item handed from front to back
  typedef struct packed {
    logic  is_start;
    byte_t b0;
    byte_t b1;
    byte_t b2;
    logic  close;
  } cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ----- hdl/fpf_if.sv -----
// valid/ready channel interfaces for input items and output bytes
`default_nettype none
interface fpf_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  fpf_pkg::byte_t      msg_type;
  fpf_pkg::byte_t      data_id;
  fpf_pkg::byte_t      payload_len;
  fpf_pkg::byte_t      data_byte;

  modport source (
    output valid, opcode, msg_type, data_id, payload_len, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, msg_type, data_id, payload_len, data_byte,
    output ready
  );
endinterface

interface fpf_out_if;
  logic           valid;
  logic           ready;
  fpf_pkg::byte_t out_byte;
  logic           last_of_packet;

  modport source (
    output valid, out_byte, last_of_packet,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_of_packet,
    output ready
  );
endinterface
`default_nettype wire

// ----- hdl/fpf_front.sv -----
// front end: accepts items, tracks packet framing, pushes classified commands
`default_nettype none
module fpf_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  fpf_in_if.sink              in_i,
  input  fpf_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output fpf_pkg::cmd_t       cmd_o
);

  logic           open_q, open_d;
  fpf_pkg::byte_t left_q, left_d;
  logic           xfer;

  assign in_i.ready = !stat_i.full;
  assign xfer       = in_i.valid && in_i.ready;

  always_comb begin
    open_d          = open_q;
    left_d          = left_q;
    push_o          = 1'b0;
    cmd_o.is_start  = 1'b0;
    cmd_o.b0        = in_i.data_byte;
    cmd_o.b1        = in_i.data_id;
    cmd_o.b2        = in_i.payload_len;
    cmd_o.close     = 1'b0;
    if (xfer) begin
      if (in_i.opcode == fpf_pkg::OP_START) begin
        push_o         = 1'b1;
        cmd_o.is_start = 1'b1;
        cmd_o.b0       = in_i.msg_type;
        cmd_o.close    = (in_i.payload_len == '0);
        left_d         = in_i.payload_len;
        open_d         = (in_i.payload_len != '0);
      end else if (open_q) begin
        push_o      = 1'b1;
        cmd_o.close = (left_q == fpf_pkg::byte_t'(1));
        left_d      = left_q - fpf_pkg::byte_t'(1);
        open_d      = (left_q != fpf_pkg::byte_t'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fpf_queue.sv -----
// short command queue between front and back
`default_nettype none
module fpf_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  fpf_pkg::cmd_t        cmd_i,
  input  wire                  pop_i,
  output fpf_pkg::cmd_t        head_o,
  output logic                 valid_o,
  output fpf_pkg::fifo_stat_t  stat_o
);

  fpf_pkg::cmd_t                  mem_q [fpf_pkg::FifoDepth];
  logic [fpf_pkg::FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [fpf_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign stat_o.full = (cnt_q == fpf_pkg::FifoCntW'(fpf_pkg::FifoDepth));
  assign valid_o     = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign do_push     = push_i && !stat_o.full;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + fpf_pkg::FifoPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + fpf_pkg::FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + fpf_pkg::FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - fpf_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fpf_back.sv -----
// back end: emits packet bytes, folds fletcher sums, appends check bytes
`default_nettype none
module fpf_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fpf_pkg::cmd_t       head_i,
  input  wire                 valid_i,
  output logic                pop_o,
  fpf_out_if.source           out_o
);

  localparam logic [fpf_pkg::ByteW:0] Mod = 9'd255;

  function automatic fpf_pkg::byte_t mod255(input logic [fpf_pkg::ByteW:0] v);
    logic [fpf_pkg::ByteW:0] r;
    begin
      r = (v >= Mod) ? v - Mod : v;
      mod255 = r[fpf_pkg::ByteW-1:0];
    end
  endfunction

  fpf_pkg::step_e step_q, step_d;
  fpf_pkg::byte_t sum_low_q, sum_low_d, sum_high_q, sum_high_d;
  fpf_pkg::byte_t c0_q, c0_d;
  fpf_pkg::byte_t out_byte_q, out_byte_d;
  logic           last_q, last_d;
  logic           out_valid_q, out_valid_d;
  logic           adv, fold;
  fpf_pkg::byte_t cur, base_low, base_high, c0, c1;

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.last_of_packet = last_q;

  always_comb begin
    adv        = valid_i && (!out_valid_q || out_o.ready);
    base_low   = (step_q == fpf_pkg::STEP_FIRST && head_i.is_start) ? '0 : sum_low_q;
    base_high  = (step_q == fpf_pkg::STEP_FIRST && head_i.is_start) ? '0 : sum_high_q;
    c0         = 8'hff - mod255({1'b0, sum_low_q} + {1'b0, sum_high_q});
    c1         = 8'hff - mod255({1'b0, sum_low_q} + {1'b0, c0_q});
    step_d     = step_q;
    pop_o      = 1'b0;
    fold       = 1'b0;
    cur        = head_i.b0;
    last_d     = 1'b0;
    case (step_q)
      fpf_pkg::STEP_FIRST: begin
        cur  = head_i.b0;
        fold = 1'b1;
        if (head_i.is_start) begin
          step_d = fpf_pkg::STEP_HDR1;
        end else if (head_i.close) begin
          step_d = fpf_pkg::STEP_CHK0;
        end else begin
          pop_o = adv;
        end
      end
      fpf_pkg::STEP_HDR1: begin
        cur    = head_i.b1;
        fold   = 1'b1;
        step_d = fpf_pkg::STEP_HDR2;
      end
      fpf_pkg::STEP_HDR2: begin
        cur  = head_i.b2;
        fold = 1'b1;
        if (head_i.close) begin
          step_d = fpf_pkg::STEP_CHK0;
        end else begin
          step_d = fpf_pkg::STEP_FIRST;
          pop_o  = adv;
        end
      end
      fpf_pkg::STEP_CHK0: begin
        cur    = c0;
        step_d = fpf_pkg::STEP_CHK1;
      end
      fpf_pkg::STEP_CHK1: begin
        cur    = c1;
        last_d = 1'b1;
        step_d = fpf_pkg::STEP_FIRST;
        pop_o  = adv;
      end
      default: begin
        step_d = fpf_pkg::STEP_FIRST;
      end
    endcase
    sum_low_d  = mod255({1'b0, base_low} + {1'b0, cur});
    sum_high_d = mod255({1'b0, base_high} + {1'b0, sum_low_d});
    c0_d       = (step_q == fpf_pkg::STEP_CHK0) ? c0 : c0_q;
    out_byte_d = cur;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    if (!adv) begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= fpf_pkg::STEP_FIRST;
      sum_low_q   <= '0;
      sum_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (adv && fold) begin
        sum_low_q  <= sum_low_d;
        sum_high_q <= sum_high_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= out_byte_d;
      last_q     <= last_d;
      c0_q       <= c0_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/fletcher16_packet_framer.sv -----
// top level of the fletcher-16 packet framer
//
// Takes start items (message type, data id, payload length) and payload bytes,
// and sends out the packet one byte per transfer: three header bytes, the payload,
// then check bytes c0 and c1 that bring the Fletcher-16 sum of the packet to
// zero, with last_of_packet set on c1. Payload with no open packet is dropped,
// and a new start abandons an open packet. The input side takes one item per
// cycle while the four-entry command queue has room; the output side sends one
// byte per cycle while the receiver is ready: three bytes for a start (five
// with zero length), one for a payload byte (three when it closes the packet).
// The output register stays full under back-pressure while the queue fills.
`default_nettype none
module fletcher16_packet_framer (
  input  wire       clk_i,
  input  wire       rst_ni,
  fpf_in_if.sink    in_i,
  fpf_out_if.source out_o
);

  logic                 push;
  fpf_pkg::cmd_t        cmd;
  fpf_pkg::cmd_t        head;
  logic                 head_valid;
  logic                 pop;
  fpf_pkg::fifo_stat_t  stat;

  fpf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (cmd)
  );

  fpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .stat_o  (stat)
  );

  fpf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .valid_i (head_valid),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

// ----- bench/fletcher16_packet_framer_test.sv -----
// testbench for the fletcher-16 packet framer, checking every byte on the wire against a packet predictor
`timescale 1ns / 100ps
module fletcher16_packet_framer_test;
  import fpf_pkg::*;

  localparam int unsigned FletcherMod = 255;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldLen     = 150;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandItems   = 430;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    opcode_e op;
    byte_t   msg_type;
    byte_t   data_id;
    byte_t   payload_len;
    byte_t   data_byte;
  } frame_item_t;

  typedef struct packed {
    byte_t value;
    logic  last;
  } wire_byte_t;

  class fletcher_scoreboard;
    int unsigned sum_low;
    int unsigned sum_high;
    int unsigned bytes_left;
    bit          packet_open;
    wire_byte_t  wire_bytes_due[$];
    int unsigned errors;

    function void fold(byte_t b);
      sum_low  = (sum_low + b) % FletcherMod;
      sum_high = (sum_high + sum_low) % FletcherMod;
    endfunction

    function void emit(byte_t b, logic last);
      wire_byte_t wb;
      wb.value = b;
      wb.last  = last;
      wire_bytes_due.push_back(wb);
    endfunction

    function void emit_check_bytes();
      int unsigned c0;
      int unsigned c1;
      c0 = 255 - ((sum_low + sum_high) % FletcherMod);
      c1 = 255 - ((sum_low + c0) % FletcherMod);
      emit(byte_t'(c0), 1'b0);
      emit(byte_t'(c1), 1'b1);
    endfunction

    // returns 1 when the item puts bytes on the wire
    function bit frame_item(frame_item_t it);
      if (it.op == OP_START) begin
        sum_low  = 0;
        sum_high = 0;
        fold(it.msg_type);
        emit(it.msg_type, 1'b0);
        fold(it.data_id);
        emit(it.data_id, 1'b0);
        fold(it.payload_len);
        emit(it.payload_len, 1'b0);
        bytes_left = it.payload_len;
        packet_open = (it.payload_len != 0);
        if (it.payload_len == 0) emit_check_bytes();
        return 1'b1;
      end
      if (!packet_open) return 1'b0;
      fold(it.data_byte);
      emit(it.data_byte, 1'b0);
      bytes_left = (bytes_left - 1) & 8'hff;
      if (bytes_left == 0) begin
        packet_open = 1'b0;
        emit_check_bytes();
      end
      return 1'b1;
    endfunction

    function void check_byte(byte_t b, logic last);
      wire_byte_t exp;
      if (wire_bytes_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected byte %02h last %0b", b, last);
        return;
      end
      exp = wire_bytes_due.pop_front();
      if (exp.value !== b || exp.last !== last) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   exp.value, exp.last, b, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fpf_in_if  in_ch ();
  fpf_out_if out_ch ();

  fletcher16_packet_framer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fletcher_scoreboard sb;
  int unsigned        burst_left;
  int unsigned        useful_items;
  bit                 hold_off_req;
  int unsigned        cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic frame_item_t start_item(byte_t msg, byte_t id, byte_t len);
    frame_item_t it;
    it.op          = OP_START;
    it.msg_type    = msg;
    it.data_id     = id;
    it.payload_len = len;
    it.data_byte   = byte_t'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic frame_item_t payload_item(byte_t data);
    frame_item_t it;
    it.op          = OP_PAYLOAD;
    it.msg_type    = byte_t'($urandom_range(0, 255));
    it.data_id     = byte_t'($urandom_range(0, 255));
    it.payload_len = byte_t'($urandom_range(0, 255));
    it.data_byte   = data;
    return it;
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic byte_t pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 80) return byte_t'($urandom_range(1, 7));
    if (r < 97) return byte_t'($urandom_range(8, 40));
    return byte_t'($urandom_range(41, 255));
  endfunction

  task automatic send_item(frame_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.op;
    in_ch.msg_type    <= it.msg_type;
    in_ch.data_id     <= it.data_id;
    in_ch.payload_len <= it.payload_len;
    in_ch.data_byte   <= it.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.frame_item(it)) useful_items++;
  endtask

  task automatic send_packet(byte_t len, int unsigned n_payload);
    send_item(start_item(rand_byte(), rand_byte(), len));
    repeat (n_payload) send_item(payload_item(rand_byte()));
  endtask

  // receiver: ready pattern by modes, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_cycles;
    mode         = 0;
    mode_left    = 0;
    hold_cycles  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_cycles  = HoldLen;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ~out_ch.ready;
          2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_byte(out_ch.out_byte, out_ch.last_of_packet);
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned n;
    byte_t       len;
    sb                = new();
    burst_left        = 0;
    useful_items      = 0;
    hold_off_req      = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_START;
    in_ch.msg_type    = '0;
    in_ch.data_id     = '0;
    in_ch.payload_len = '0;
    in_ch.data_byte   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle payload, zero length, extremes, abandon, overlong
    send_item(payload_item(8'hff));
    send_item(start_item(8'h00, 8'h00, 8'h00));
    send_item(start_item(8'hff, 8'hff, 8'h00));
    send_item(start_item(8'haa, 8'h55, 8'h01));
    send_item(payload_item(8'hff));
    send_item(start_item(8'h01, 8'hfe, 8'h02));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'hff));
    send_item(payload_item(8'h5a));
    send_item(start_item(8'h80, 8'h01, 8'hff));
    send_item(payload_item(8'h7f));
    send_item(start_item(8'h7f, 8'h80, 8'h03));
    send_item(payload_item(8'h01));
    send_item(payload_item(8'h80));
    send_item(payload_item(8'hfe));
    send_item(start_item(8'hff, 8'h00, 8'h01));
    send_item(payload_item(8'h00));

    // random: mostly well-formed packets, some abandoned, overlong or stray
    hold_off_req = 1'b1;
    useful_items = 0;
    while (useful_items < RandItems) begin
      r   = $urandom_range(0, 99);
      len = pick_len();
      if (r < 80) begin
        n = len;
        if (len > 40 && $urandom_range(0, 9) < 7) n = $urandom_range(1, 30);
        send_packet(len, n);
      end else if (r < 90) begin
        send_packet(len, len == 0 ? 0 : $urandom_range(0, len - 1));
      end else if (r < 95) begin
        send_packet(len, len + $urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(payload_item(rand_byte()));
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.wire_bytes_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.wire_bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- fletcher16_packet_framer.f -----
hdl/fpf_pkg.sv
hdl/fpf_if.sv
hdl/fpf_front.sv
hdl/fpf_queue.sv
hdl/fpf_back.sv
hdl/fletcher16_packet_framer.sv
bench/fletcher16_packet_framer_test.sv
